// File: hdl/mlcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlcb_pkg
// Shared types, constants and tables of the mouse-look camera basis block.
// ----------------------------------------------------------------------------
package mlcb_pkg;

    // Fraction bits of the vector outputs.
    localparam int VECTOR_FRAC_BITS = 14;
    // Right shift from a Q4.60 product down to the output format.
    localparam int OUT_SHIFT = 60 - VECTOR_FRAC_BITS;

    // Port widths.
    localparam int IN_W        = 32;
    localparam int OUT_W       = 184;
    localparam int CFG_DATA_W  = 25;
    localparam int CFG_INDEX_W = 3;
    localparam int IDX_W       = 4;

    // Angles are in 1/65536 degree.
    localparam logic [24:0] TURN    = 25'd23592960;
    localparam logic [24:0] HALF    = 25'd11796480;
    localparam logic [24:0] QUARTER = 25'd5898240;
    localparam logic [24:0] EIGHTH  = 25'd2949120;
    localparam logic [33:0] TURN34  = 34'd23592960;
    // 512 turns, added so that the yaw sum is never negative.
    localparam logic [33:0] WRAP_BIAS = 34'd12079595520;
    // Highest shift of one turn in the restoring yaw reduction.
    localparam logic [IDX_W-1:0] WRAP_TOP = 4'd9;

    // Degree-to-radian factor round(pi/180 * 2^46), split at bit 32.
    localparam logic [8:0]  RAD_KH = 9'd285;
    localparam logic [31:0] RAD_KL = 32'd4100597034;

    localparam logic [30:0]        ONE30   = 31'h4000_0000;
    localparam logic signed [31:0] ONE30_S = 32'sh4000_0000;

    // Series terms: sine terms first, then cosine terms.
    localparam logic [IDX_W-1:0] LAST_SIN_TERM = 4'd5;
    localparam logic [IDX_W-1:0] LAST_TERM     = 4'd12;
    localparam logic [1:0]       LAST_PROD     = 2'd3;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_YAW_START   = 3'd0,
        CFG_PITCH_START = 3'd1,
        CFG_SENSITIVITY = 3'd2,
        CFG_PITCH_UPPER = 3'd3,
        CFG_PITCH_LOWER = 3'd4
    } cfg_idx_t;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DELTA,
        OP_CLAMP,
        OP_WRAP,
        OP_ALOAD,
        OP_AQ2,
        OP_AQ1,
        OP_FOLD,
        OP_XLO,
        OP_XHI,
        OP_XSQ,
        OP_TMUL,
        OP_TRCP,
        OP_TACC,
        OP_ASTORE,
        OP_PROD,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic             ang;   // 0: yaw, 1: pitch
    } cmd_t;

    typedef struct packed {
        logic out_full;          // result register holds an item not yet taken
    } stat_t;

    // Integer factor that divides each series term.
    function automatic logic [7:0] term_div(input logic [IDX_W-1:0] j);
        logic [7:0] d;
        unique case (j)
            4'd0:    d = 8'd6;
            4'd1:    d = 8'd20;
            4'd2:    d = 8'd42;
            4'd3:    d = 8'd72;
            4'd4:    d = 8'd110;
            4'd5:    d = 8'd156;
            4'd6:    d = 8'd2;
            4'd7:    d = 8'd12;
            4'd8:    d = 8'd30;
            4'd9:    d = 8'd56;
            4'd10:   d = 8'd90;
            4'd11:   d = 8'd132;
            4'd12:   d = 8'd182;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

    // floor(2^31 / term_div(j)); the quotient estimate is low by at most one.
    function automatic logic [30:0] term_rcp(input logic [IDX_W-1:0] j);
        logic [30:0] m;
        unique case (j)
            4'd0:    m = 31'd357913941;
            4'd1:    m = 31'd107374182;
            4'd2:    m = 31'd51130563;
            4'd3:    m = 31'd29826161;
            4'd4:    m = 31'd19522578;
            4'd5:    m = 31'd13765920;
            4'd6:    m = 31'd1073741824;
            4'd7:    m = 31'd178956970;
            4'd8:    m = 31'd71582788;
            4'd9:    m = 31'd38347922;
            4'd10:   m = 31'd23860929;
            4'd11:   m = 31'd16268815;
            4'd12:   m = 31'd11799360;
            default: m = 31'd0;
        endcase
        return m;
    endfunction

    // Q4.60 to the output format, nearest with ties away from zero.
    function automatic logic [15:0] round_out(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r   = (mag + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        if (v[63])
        begin
            r = 64'(-r);
        end
        return r[15:0];
    endfunction

endpackage

// File: hdl/mlcb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlcb_ctrl
// Sequencer: steps the datapath through update, reduction, sine-cosine
// series and output products for one item at a time.
// ----------------------------------------------------------------------------
module mlcb_ctrl
    import mlcb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  stat_t stat,
    output logic  in_ready,
    output cmd_t  cmd
);

    typedef enum logic [16:0] {
        ST_IDLE   = 17'h00001,
        ST_DELTA  = 17'h00002,
        ST_CLAMP  = 17'h00004,
        ST_WRAP   = 17'h00008,
        ST_ALOAD  = 17'h00010,
        ST_AQ2    = 17'h00020,
        ST_AQ1    = 17'h00040,
        ST_FOLD   = 17'h00080,
        ST_XLO    = 17'h00100,
        ST_XHI    = 17'h00200,
        ST_XSQ    = 17'h00400,
        ST_TMUL   = 17'h00800,
        ST_TRCP   = 17'h01000,
        ST_TACC   = 17'h02000,
        ST_ASTORE = 17'h04000,
        ST_PROD   = 17'h08000,
        ST_OUT    = 17'h10000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             ang_reg, ang_next;

    // State and step counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            ang_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ang_reg   <= ang_next;
        end
    end

    // Next state and datapath command.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ang_next   = ang_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.idx    = idx_reg;
        cmd.ang    = ang_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA:
            begin
                cmd.op     = OP_DELTA;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.op     = OP_CLAMP;
                idx_next   = WRAP_TOP;
                state_next = ST_WRAP;
            end
            ST_WRAP:
            begin
                cmd.op = OP_WRAP;
                if (idx_reg == '0)
                begin
                    ang_next   = 1'b0;
                    state_next = ST_ALOAD;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_ALOAD:
            begin
                cmd.op     = OP_ALOAD;
                state_next = ST_AQ2;
            end
            ST_AQ2:
            begin
                cmd.op     = OP_AQ2;
                state_next = ST_AQ1;
            end
            ST_AQ1:
            begin
                cmd.op     = OP_AQ1;
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.op     = OP_FOLD;
                state_next = ST_XLO;
            end
            ST_XLO:
            begin
                cmd.op     = OP_XLO;
                state_next = ST_XHI;
            end
            ST_XHI:
            begin
                cmd.op     = OP_XHI;
                state_next = ST_XSQ;
            end
            ST_XSQ:
            begin
                cmd.op     = OP_XSQ;
                idx_next   = '0;
                state_next = ST_TMUL;
            end
            ST_TMUL:
            begin
                cmd.op     = OP_TMUL;
                state_next = ST_TRCP;
            end
            ST_TRCP:
            begin
                cmd.op     = OP_TRCP;
                state_next = ST_TACC;
            end
            ST_TACC:
            begin
                cmd.op = OP_TACC;
                if (idx_reg == LAST_TERM)
                begin
                    state_next = ST_ASTORE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TMUL;
                end
            end
            ST_ASTORE:
            begin
                cmd.op = OP_ASTORE;
                if (!ang_reg)
                begin
                    ang_next   = 1'b1;
                    state_next = ST_ALOAD;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                cmd.op = OP_PROD;
                if (idx_reg[1:0] == LAST_PROD)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                // Wait until the result register is free.
                if (!stat.out_full)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/mlcb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlcb_dp
// Datapath: angle state and configuration, yaw reduction, a shared
// sine-cosine series unit and the result register.
// ----------------------------------------------------------------------------
module mlcb_dp
    import mlcb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    input  logic [IN_W-1:0]        in_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_W-1:0]       out_data
);

    // Configuration and angle state.
    logic [15:0]        sens_reg;
    logic signed [23:0] upper_reg, lower_reg;
    logic [24:0]        yaw_reg;
    logic signed [23:0] pitch_reg;
    logic signed [15:0] prevx_reg, prevy_reg;
    logic               seen_reg;

    // Working registers.
    logic signed [16:0] dx_reg, dy_reg;
    logic [33:0]        wacc_reg;
    logic signed [33:0] psum_reg;
    logic [24:0]        a_reg;
    logic [1:0]         quad_reg;
    logic               swap_reg;
    logic [21:0]        r_reg;
    logic [53:0]        p0_reg;
    logic [29:0]        x_reg, x2_reg;
    logic [30:0]        t_reg, q0_reg;
    logic signed [31:0] sum_reg, sraw_reg;
    logic signed [31:0] sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [63:0] prod_reg [4];
    logic [OUT_W-1:0]   out_data_reg;
    logic               out_valid_reg;

    // Combinational helpers.
    logic signed [15:0] mx, my;
    logic signed [16:0] dx_c, dy_c;
    logic signed [16:0] sens_s;
    logic signed [33:0] ydel_c, pdel_c;
    logic signed [33:0] up34, lo34, pclip_c;
    logic [33:0]        wsub_c, wacc_c;
    logic [24:0]        pwrap_c;
    logic [53:0]        p0_c;
    logic [30:0]        rkh_c;
    logic [21:0]        xrnd_c;
    logic [59:0]        sq_c;
    logic [60:0]        tm_c;
    logic [61:0]        rp_c;
    logic [7:0]         div_c;
    logic [38:0]        qd_c, rem_c;
    logic [30:0]        q_c;
    logic signed [31:0] sumq_c;
    logic signed [31:0] sc_c, cc_c, s0_c, c0_c, s_c, c_c;
    logic signed [31:0] pa_c, pb_c;
    logic signed [63:0] pr_c;
    logic signed [63:0] sy60, cy60, sp60, cp60;

    assign mx = $signed(in_data[15:0]);
    assign my = $signed(in_data[31:16]);

    // Pointer motion; the first item causes none.
    assign dx_c = seen_reg ? (17'(mx) - 17'(prevx_reg)) : '0;
    assign dy_c = seen_reg ? (17'(prevy_reg) - 17'(my)) : '0;

    // Angle increments.
    assign sens_s = $signed({1'b0, sens_reg});
    assign ydel_c = dx_reg * sens_s;
    assign pdel_c = dy_reg * sens_s;

    // Pitch clamp: upper limit first, then lower.
    assign up34    = 34'(upper_reg);
    assign lo34    = 34'(lower_reg);
    assign pclip_c = (psum_reg >= up34) ? up34 : psum_reg;

    // One restoring step of the yaw reduction modulo one turn.
    assign wsub_c = TURN34 << cmd.idx;
    assign wacc_c = (wacc_reg >= wsub_c) ? (wacc_reg - wsub_c) : wacc_reg;

    // Negative pitch mapped into one turn.
    assign pwrap_c = TURN + 25'(pitch_reg);

    // Radian conversion and square.
    assign p0_c   = r_reg * RAD_KL;
    assign rkh_c  = r_reg * RAD_KH;
    assign xrnd_c = 22'((p0_reg + (54'd1 << 31)) >> 32);
    assign sq_c   = x_reg * x_reg;

    // Series term: multiply by x^2, then divide by the term factor.
    assign tm_c   = t_reg * x2_reg;
    assign rp_c   = t_reg * term_rcp(cmd.idx);
    assign div_c  = term_div(cmd.idx);
    assign qd_c   = q0_reg * div_c;
    assign rem_c  = 39'(t_reg) - qd_c;
    assign q_c    = (rem_c >= 39'(div_c)) ? (q0_reg + 1'b1) : q0_reg;
    assign sumq_c = cmd.idx[0] ? (sum_reg + $signed({1'b0, q_c}))
                               : (sum_reg - $signed({1'b0, q_c}));

    // Octant results clamped to [0, 1], folded and placed in the quadrant.
    always_comb
    begin
        sc_c = (sraw_reg > ONE30_S) ? ONE30_S : ((sraw_reg < 0) ? '0 : sraw_reg);
        cc_c = (sum_reg > ONE30_S) ? ONE30_S : ((sum_reg < 0) ? '0 : sum_reg);
        s0_c = swap_reg ? cc_c : sc_c;
        c0_c = swap_reg ? sc_c : cc_c;
        unique case (quad_reg)
            2'd0:
            begin
                s_c = s0_c;
                c_c = c0_c;
            end
            2'd1:
            begin
                s_c = c0_c;
                c_c = -s0_c;
            end
            2'd2:
            begin
                s_c = -s0_c;
                c_c = -c0_c;
            end
            default:
            begin
                s_c = -c0_c;
                c_c = s0_c;
            end
        endcase
    end

    // Operands of the output products.
    always_comb
    begin
        unique case (cmd.idx[1:0])
            2'd0:
            begin
                pa_c = cy_reg;
                pb_c = cp_reg;
            end
            2'd1:
            begin
                pa_c = sy_reg;
                pb_c = cp_reg;
            end
            2'd2:
            begin
                pa_c = cy_reg;
                pb_c = sp_reg;
            end
            default:
            begin
                pa_c = sy_reg;
                pb_c = sp_reg;
            end
        endcase
    end
    assign pr_c = pa_c * pb_c;

    // Single values scaled to Q4.60.
    assign sy60 = 64'(sy_reg) <<< 30;
    assign cy60 = 64'(cy_reg) <<< 30;
    assign sp60 = 64'(sp_reg) <<< 30;
    assign cp60 = 64'(cp_reg) <<< 30;

    // Configuration and angle state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg  <= 16'd6554;
            upper_reg <= 24'sd5832704;
            lower_reg <= -24'sd5832704;
            yaw_reg   <= '0;
            pitch_reg <= '0;
            prevx_reg <= '0;
            prevy_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_YAW_START:
                    begin
                        yaw_reg <= (cfg_data >= TURN) ? (cfg_data - TURN) : cfg_data;
                    end
                    CFG_PITCH_START: pitch_reg <= $signed(cfg_data[23:0]);
                    CFG_SENSITIVITY: sens_reg  <= cfg_data[15:0];
                    CFG_PITCH_UPPER: upper_reg <= $signed(cfg_data[23:0]);
                    CFG_PITCH_LOWER: lower_reg <= $signed(cfg_data[23:0]);
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.op == OP_LOAD)
            begin
                prevx_reg <= mx;
                prevy_reg <= my;
                seen_reg  <= 1'b1;
            end
            if (cmd.op == OP_CLAMP)
            begin
                pitch_reg <= (pclip_c <= lo34) ? lower_reg : pclip_c[23:0];
            end
            if ((cmd.op == OP_WRAP) && (cmd.idx == '0))
            begin
                yaw_reg <= wacc_c[24:0];
            end
        end
    end

    // Working registers of the update and the series unit.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                dx_reg <= dx_c;
                dy_reg <= dy_c;
            end
            OP_DELTA:
            begin
                wacc_reg <= 34'(yaw_reg) + WRAP_BIAS + 34'(ydel_c);
                psum_reg <= 34'(pitch_reg) + pdel_c;
            end
            OP_WRAP:
            begin
                wacc_reg <= wacc_c;
            end
            OP_ALOAD:
            begin
                a_reg    <= cmd.ang ? (pitch_reg[23] ? pwrap_c : 25'(pitch_reg)) : yaw_reg;
                quad_reg <= 2'd0;
            end
            OP_AQ2:
            begin
                if (a_reg >= HALF)
                begin
                    a_reg       <= a_reg - HALF;
                    quad_reg[1] <= 1'b1;
                end
            end
            OP_AQ1:
            begin
                if (a_reg >= QUARTER)
                begin
                    a_reg       <= a_reg - QUARTER;
                    quad_reg[0] <= 1'b1;
                end
            end
            OP_FOLD:
            begin
                if (a_reg <= EIGHTH)
                begin
                    r_reg    <= a_reg[21:0];
                    swap_reg <= 1'b0;
                end
                else
                begin
                    r_reg    <= 22'(QUARTER - a_reg);
                    swap_reg <= 1'b1;
                end
            end
            OP_XLO:
            begin
                p0_reg <= p0_c;
            end
            OP_XHI:
            begin
                x_reg <= 30'(rkh_c) + 30'(xrnd_c);
            end
            OP_XSQ:
            begin
                x2_reg  <= 30'((sq_c + (60'd1 << 29)) >> 30);
                t_reg   <= 31'(x_reg);
                sum_reg <= $signed(32'(x_reg));
            end
            OP_TMUL:
            begin
                t_reg <= 31'((tm_c + (61'd1 << 29)) >> 30);
            end
            OP_TRCP:
            begin
                q0_reg <= rp_c[61:31];
            end
            OP_TACC:
            begin
                if (cmd.idx == LAST_SIN_TERM)
                begin
                    // Sine done; the cosine series starts at one.
                    sraw_reg <= sumq_c;
                    t_reg    <= ONE30;
                    sum_reg  <= ONE30_S;
                end
                else
                begin
                    t_reg   <= q_c;
                    sum_reg <= sumq_c;
                end
            end
            OP_ASTORE:
            begin
                if (cmd.ang)
                begin
                    sp_reg <= s_c;
                    cp_reg <= c_c;
                end
                else
                begin
                    sy_reg <= s_c;
                    cy_reg <= c_c;
                end
            end
            OP_PROD:
            begin
                prod_reg[cmd.idx[1:0]] <= pr_c;
            end
            OP_OUT:
            begin
                out_data_reg <= {7'd0, pitch_reg, yaw_reg,
                                 round_out(-prod_reg[3]),
                                 round_out(cp60),
                                 round_out(-prod_reg[2]),
                                 round_out(cy60),
                                 round_out(-sy60),
                                 round_out(prod_reg[1]),
                                 round_out(sp60),
                                 round_out(prod_reg[0])};
            end
            default:
            begin
            end
        endcase
    end

    // Result register handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_full = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule

// File: hdl/mouse_look_camera_basis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_look_camera_basis
// Mouse-look camera: yaw and pitch from pointer motion, and the unit front,
// right and up vectors of the camera.
// ----------------------------------------------------------------------------
// Usage:
// Each input item on the s_t* channel is one pointer position. The block
// turns yaw by sensitivity times the x motion and pitch by sensitivity
// times the inverted y motion, clamps pitch to its limits and returns one
// item on the m_t* channel with the basis vectors in Q2.14 and both angles.
// The first item after reset records the position and causes no motion.
// From acceptance to the result in the output register, ten restoring
// steps reduce yaw to one turn, then one shared sine-cosine unit runs
// once per angle (13 series terms of three steps each), and four
// product steps follow. s_tready is high only while the block is idle,
// so the next item waits until the last result is stored.
// A result waits in the output register while m_tready is low; the block
// meanwhile takes and processes the next item and holds its own result until
// the register is free. Reset clears the angles, the previous position and
// the first-item flag and loads the default registers. Configuration writes
// take effect at once; the block relies on the user to make them while idle.
// ----------------------------------------------------------------------------
module mouse_look_camera_basis
    import mlcb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input item: mouse_x [15:0], mouse_y [31:16].
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_W-1:0]        s_tdata,
    // Result item: front_x [15:0], front_y [31:16], front_z [47:32],
    // right_x [63:48], right_z [79:64], up_x [95:80], up_y [111:96],
    // up_z [127:112], yaw_now [152:128], pitch_now [176:153], zeros above.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_W-1:0]       m_tdata,
    // Configuration write port.
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    mlcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    // Datapath and result register.
    mlcb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// File: hdl/mlcb_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlcb_chk
// Port checker of the mouse-look camera basis block.
// ----------------------------------------------------------------------------
module mlcb_chk
    import mlcb_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // After an item is taken the block is busy with it.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item taken while the previous one is in work");

    // Yaw is always reduced to one turn.
    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[152:128] < TURN))
        else $error("yaw outside one turn");

    // The front_x component stays within one.
    a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (($signed(m_tdata[15:0]) <= 16'sd16384) &&
                      ($signed(m_tdata[15:0]) >= -16'sd16384)))
        else $error("front_x beyond unit length");

endmodule

bind mouse_look_camera_basis mlcb_chk u_mlcb_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mouse-look camera basis block. Pointer items
// are driven on the input stream, each accepted item is run through a local
// model of the yaw/pitch update and the series sine-cosine, and every result
// item is compared field by field against the oldest predicted basis.
// ----------------------------------------------------------------------------
module tb_top;
    import mlcb_pkg::*;

    localparam int           LIMIT_CYCLES = 5000000;
    localparam longint       ONE_TURN     = 64'd23592960;
    localparam longint       PITCH_MAX    = 64'd5898240;
    localparam longint       LIMIT_MAX    = 64'd5832704;
    localparam longint       RAD_SCALE    = 64'd1228166276394;
    localparam longint       Q30_ONE      = 64'd1073741824;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct {
        logic [15:0] vec [8];
        logic [24:0] yaw;
        logic [23:0] pitch;
    } basis_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_W-1:0]       m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Camera state mirrored by the bench.
    longint   cam_yaw, cam_pitch, last_x, last_y;
    bit       seen_move;
    longint   sens, lim_hi, lim_lo;
    basis_t   basis_q [$];
    int       mismatches;
    int       cycles;
    bit       hold_long;
    logic [15:0] cur_x, cur_y;

    mouse_look_camera_basis uut (.*);

    // Clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Cycle counter with timeout.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint wrap_angle(input longint v);
        longint m;
        m = v % ONE_TURN;
        if (m < 0)
            m += ONE_TURN;
        return m;
    endfunction

    function automatic longint sext_val(input longint v, input int w);
        longint m;
        m = v & ((64'd1 << w) - 1);
        if (m[w-1])
            m -= (64'd1 << w);
        return m;
    endfunction

    // Sine and cosine in Q2.30 for an angle within one eighth of a turn.
    function automatic void octant_q30(input longint r, output longint s, output longint c);
        longint unsigned x, x2, t;
        longint          acc;
        x   = (longint'(r) * RAD_SCALE + (64'd1 << 31)) >> 32;
        x2  = (x * x + (64'd1 << 29)) >> 30;
        t   = x;
        acc = x;
        for (int k = 1; k <= 6; k++)
        begin
            t = (t * x2 + (64'd1 << 29)) >> 30;
            t = t / ((2 * k) * (2 * k + 1));
            acc = (k % 2) ? acc - longint'(t) : acc + longint'(t);
        end
        s = (acc > Q30_ONE) ? Q30_ONE : ((acc < 0) ? 0 : acc);
        t   = Q30_ONE;
        acc = Q30_ONE;
        for (int k = 1; k <= 7; k++)
        begin
            t = (t * x2 + (64'd1 << 29)) >> 30;
            t = t / ((2 * k - 1) * (2 * k));
            acc = (k % 2) ? acc - longint'(t) : acc + longint'(t);
        end
        c = (acc > Q30_ONE) ? Q30_ONE : ((acc < 0) ? 0 : acc);
    endfunction

    // Full-circle sine and cosine through quadrant symmetry.
    function automatic void angle_sincos(input longint ang, output longint s, output longint c);
        longint a, q, r, s0, c0;
        a = wrap_angle(ang);
        q = a / PITCH_MAX;
        r = a % PITCH_MAX;
        if (r <= PITCH_MAX / 2)
            octant_q30(r, s0, c0);
        else
            octant_q30(PITCH_MAX - r, c0, s0);
        case (q)
            0:       begin s = s0;  c = c0;  end
            1:       begin s = c0;  c = -s0; end
            2:       begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0;  end
        endcase
    endfunction

    // Q4.60 down to the 16-bit vector format, ties away from zero.
    function automatic logic [15:0] vec_round(input longint v);
        longint unsigned mag, r;
        int sh;
        sh  = 60 - VECTOR_FRAC_BITS;
        mag = (v < 0) ? -v : v;
        r   = (mag + (64'd1 << (sh - 1))) >> sh;
        if (v < 0)
            r = -r;
        return r[15:0];
    endfunction

    // Advances the camera for one pointer item and returns the expected basis.
    function automatic basis_t camera_step(input logic [IN_W-1:0] d);
        basis_t b;
        longint mx, my, sy, cy, sp, cp;
        mx = longint'($signed(d[15:0]));
        my = longint'($signed(d[31:16]));
        if (!seen_move)
        begin
            last_x    = mx;
            last_y    = my;
            seen_move = 1'b1;
        end
        cam_yaw   = wrap_angle(cam_yaw + (mx - last_x) * sens);
        cam_pitch = cam_pitch + (last_y - my) * sens;
        last_x    = mx;
        last_y    = my;
        if (cam_pitch >= lim_hi)
            cam_pitch = lim_hi;
        if (cam_pitch <= lim_lo)
            cam_pitch = lim_lo;
        angle_sincos(cam_yaw, sy, cy);
        angle_sincos(cam_pitch, sp, cp);
        b.vec[0] = vec_round(cy * cp);
        b.vec[1] = vec_round(sp * Q30_ONE);
        b.vec[2] = vec_round(sy * cp);
        b.vec[3] = vec_round(-sy * Q30_ONE);
        b.vec[4] = vec_round(cy * Q30_ONE);
        b.vec[5] = vec_round(-(cy * sp));
        b.vec[6] = vec_round(cp * Q30_ONE);
        b.vec[7] = vec_round(-(sy * sp));
        b.yaw    = cam_yaw[24:0];
        b.pitch  = cam_pitch[23:0];
        return b;
    endfunction

    // Prediction on every accepted input item.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            basis_q.push_back(camera_step(s_tdata));
    end

    // Result checker.
    always @(posedge clk)
    begin
        basis_t b;
        string  names [8];
        names = '{"front_x", "front_y", "front_z", "right_x",
                  "right_z", "up_x", "up_y", "up_z"};
        if (rst_n && m_tvalid && m_tready)
        begin
            if (basis_q.size() == 0)
            begin
                $error("result item with no expectation waiting");
                mismatches++;
            end
            else
            begin
                b = basis_q.pop_front();
                for (int i = 0; i < 8; i++)
                begin
                    if (m_tdata[16*i +: 16] !== b.vec[i])
                    begin
                        $error("%s expected %0d actual %0d", names[i],
                               $signed(b.vec[i]), $signed(m_tdata[16*i +: 16]));
                        mismatches++;
                    end
                end
                if (m_tdata[152:128] !== b.yaw)
                begin
                    $error("yaw_now expected %0d actual %0d", b.yaw, m_tdata[152:128]);
                    mismatches++;
                end
                if (m_tdata[176:153] !== b.pitch)
                begin
                    $error("pitch_now expected %0d actual %0d",
                           $signed(b.pitch), $signed(m_tdata[176:153]));
                    mismatches++;
                end
            end
        end
    end

    // Receiver: random ready pattern, plus one long hold-off on request.
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_long = 1'b0;
            end
            n = $urandom_range(0, 9);
            m_tready <= (n < 7);
            if (n < 5)
                repeat ($urandom_range(1, 40)) @(posedge clk);
            else if (n < 9)
                repeat ($urandom_range(1, 6)) @(posedge clk);
            else
                repeat ($urandom_range(50, 300)) @(posedge clk);
        end
    end

    // Sends one pointer item, then sometimes leaves a random gap.
    task automatic send_mouse(input logic [15:0] x, input logic [15:0] y);
        int n;
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        cur_x = x;
        cur_y = y;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        n = $urandom_range(0, 19);
        if (n >= 12)
        begin
            s_tvalid <= 1'b0;
            if (n < 19)
                repeat ($urandom_range(1, 5)) @(posedge clk);
            else
                repeat ($urandom_range(100, 400)) @(posedge clk);
        end
    endtask

    // Waits until every expected result has arrived and the block is idle.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (basis_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write; the enable drops before the next write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input longint val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_YAW_START:   cam_yaw   = wrap_angle(val & 64'h1FF_FFFF);
            CFG_PITCH_START: cam_pitch = sext_val(val, 24);
            CFG_SENSITIVITY: sens      = val & 64'hFFFF;
            CFG_PITCH_UPPER: lim_hi    = sext_val(val, 24);
            CFG_PITCH_LOWER: lim_lo    = sext_val(val, 24);
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Random pointer motion: mostly small steps, sometimes wild jumps.
    task automatic move_random(input int count);
        logic [15:0] x, y;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                x = cur_x + 16'($signed($urandom_range(0, 400)) - 200);
                y = cur_y + 16'($signed($urandom_range(0, 400)) - 200);
            end
            else
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            send_mouse(x, y);
        end
    endtask

    // First item, field extremes, clamps, crossed limits, unknown register.
    task automatic test_directed;
        send_mouse(16'h1234, 16'h8000);
        send_mouse(16'h7FFF, 16'h8000);
        send_mouse(16'h8000, 16'h7FFF);
        send_mouse(16'h7FFF, 16'h8000);
        send_mouse(16'h0000, 16'h0000);
        send_mouse(16'hFFFF, 16'hFFFF);
        drain();
        write_reg(CFG_SENSITIVITY, 65535);
        write_reg(CFG_PITCH_UPPER, 1000000);
        write_reg(CFG_PITCH_LOWER, 2000000);
        write_reg(CFG_UNUSED_IDX, 12345);
        send_mouse(16'h7FFF, 16'h8000);
        send_mouse(16'h8000, 16'h7FFF);
        send_mouse(16'h0001, 16'h0001);
        drain();
        write_reg(CFG_PITCH_UPPER, LIMIT_MAX);
        write_reg(CFG_PITCH_LOWER, -LIMIT_MAX);
        write_reg(CFG_YAW_START, 33554431);
        write_reg(CFG_PITCH_START, -8388608);
        send_mouse(16'h0001, 16'h0001);
        send_mouse(16'h0000, 16'h8000);
        send_mouse(16'h8000, 16'h7FFF);
        drain();
        write_reg(CFG_SENSITIVITY, 0);
        write_reg(CFG_PITCH_START, PITCH_MAX);
        write_reg(CFG_YAW_START, ONE_TURN - 1);
        write_reg(CFG_PITCH_UPPER, 8388607);
        write_reg(CFG_PITCH_LOWER, -8388608);
        send_mouse(16'h5555, 16'hAAAA);
        send_mouse(16'hAAAA, 16'h5555);
        drain();
        write_reg(CFG_PITCH_START, -PITCH_MAX);
        write_reg(CFG_YAW_START, 0);
        send_mouse(16'h0000, 16'h0000);
        drain();
    endtask

    // Random motion under several register settings.
    task automatic test_random;
        for (int p = 0; p < 5; p++)
        begin
            write_reg(CFG_YAW_START, $urandom_range(0, 33554431));
            write_reg(CFG_PITCH_START, longint'($urandom_range(0, 11796480)) - PITCH_MAX);
            write_reg(CFG_SENSITIVITY, (p == 0) ? 65535 : $urandom_range(0, 65535));
            write_reg(CFG_PITCH_UPPER, longint'($urandom_range(0, 11665408)) - LIMIT_MAX);
            write_reg(CFG_PITCH_LOWER, longint'($urandom_range(0, 11665408)) - LIMIT_MAX);
            move_random(220);
            drain();
        end
    endtask

    // Long receiver hold-off while items keep coming, then a full pause and more items.
    task automatic test_backpressure;
        write_reg(CFG_SENSITIVITY, 6554);
        write_reg(CFG_PITCH_UPPER, LIMIT_MAX);
        write_reg(CFG_PITCH_LOWER, -LIMIT_MAX);
        hold_long = 1'b1;
        move_random(60);
        drain();
        move_random(40);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_YAW_START;
        cfg_data   = '0;
        cycles     = 0;
        mismatches = 0;
        hold_long  = 1'b0;
        cam_yaw    = 0;
        cam_pitch  = 0;
        last_x     = 0;
        last_y     = 0;
        seen_move  = 1'b0;
        sens       = 6554;
        lim_hi     = LIMIT_MAX;
        lim_lo     = -LIMIT_MAX;
        cur_x      = '0;
        cur_y      = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        test_backpressure();

        drain();
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
